// ----- hw/rtl/ntt_pkg.sv -----
// Package for the nearest track table: word types, codes, constants and states.
// Depends on nothing; every other file of the block but ntt_ram imports it.
`timescale 1ns / 1ps

package ntt_pkg;

   localparam int MaxTracksDefault = 16;
   localparam int ResultLimit      = 16;
   localparam int CsrIndexWidth    = 3;

   typedef enum logic [1:0] {
      OP_FRAME_START = 2'd0,
      OP_MEASURE     = 2'd1,
      OP_FRAME_END   = 2'd2,
      OP_UNUSED      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_TRACK  = 2'd1,
      KIND_EMPTY  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_UPDATED  = 2'd0,
      ST_CREATED  = 2'd1,
      ST_REJECTED = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   localparam logic [CsrIndexWidth-1:0] CSR_MATCH_DISTANCE = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_JUMP_LIMIT     = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_BLEND_WEIGHT   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_TIME_TO_LIVE   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_MIN_HITS       = 3'd4;

   typedef struct packed {
      logic [1:0]         operation;
      logic [31:0]        time_ms;
      logic signed [31:0] meas_x;
      logic signed [31:0] meas_y;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [1:0]         status;
      logic [15:0]        track_number;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [7:0]         hit_count;
      logic               last_result;
   } rsp_word_type;

   // Track record as it sits in one slot.
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [31:0]        seen;
      logic [7:0]         hits;
      logic [15:0]        ident;
   } track_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXP_RD,
      S_EXP_CHK,
      S_MEAS_RD,
      S_MEAS_CMP,
      S_MEAS_DEC,
      S_BLEND,
      S_MEAS_WR,
      S_REP_RD,
      S_REP_CHK,
      S_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;      // capture the accepted request word
      logic clr_scan;      // index and keep counter to zero, best cleared
      logic rd_issue;      // read slot at scan index
      logic exp_eval;      // expiry: copy slot down when alive
      logic exp_done;      // expiry: live count takes keep count
      logic meas_cmp;      // compare slot distance with best
      logic meas_dec;      // classify the best candidate
      logic blend;         // compute blended position
      logic meas_write;    // write back update or append
      logic rep_eval;      // report: hold the track, send the one held before
      logic rep_empty;     // report: the final word is the empty word
      logic rsp_load;      // present the final frame-end word at the output
      logic idx_inc;       // advance the scan index
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type     op;
      logic       scan_end;    // scan index reached live count
      logic       rep_hit;     // current slot qualifies for report
      logic       reported;    // at least one track held for report
      logic       rep_limit;   // report limit reached
      logic       rsp_busy;    // output register holds an unread word
   } stat_type;

endpackage

// ----- hw/rtl/nearest_track_table.sv -----
// Nearest track table: an ordered table of up to MaxTracks ground tracks with
// nearest-neighbor association, expiry at frame start and reporting at frame
// end. Each request word is handled alone. A frame start reads each live slot
// and then keeps or drops it, since every slot record passes through the
// single read port of the slot memory. A measurement reads and compares each
// live slot in the distance scan, sees the end of the scan, and then decides,
// blends and writes. A frame end reads and checks each slot until the end of
// the scan or the report limit, and then loads the final word. Result words
// wait in an output register, and a measurement write or a frame end with many
// reports pauses while that register is held by a stalled receiver.
// Configuration writes are taken at any time but belong while the block idles.
`timescale 1ns / 1ps

module nearest_track_table #(
   parameter int MaxTracks = ntt_pkg::MaxTracksDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ntt_pkg::req_word_type             req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ntt_pkg::rsp_word_type             rsp_word,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ntt_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [31:0]                       csr_data
);
   import ntt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Registers are always writable.
   assign csr_ready = 1'b1;

   ntt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ntt_datapath #(.MaxTracks(MaxTracks)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );
endmodule

// ----- hw/rtl/ntt_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module ntt_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ----- hw/rtl/ntt_ctrl.sv -----
// Controller state machine of the nearest track table.
// Depends on ntt_pkg for the state, command and status types.
`timescale 1ns / 1ps

module ntt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ntt_pkg::stat_type stat,
   output ntt_pkg::cmd_type  cmd
);
   import ntt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cmd.clr_scan = 1'b1;
               state_in     = S_IDLE;
            end
            if (stat.op == OP_FRAME_START) state_in = S_EXP_RD;
            else if (stat.op == OP_MEASURE) state_in = S_MEAS_RD;
            else if (stat.op == OP_FRAME_END) state_in = S_REP_RD;
            if (!req_valid) state_in = S_IDLE;
         end
         S_EXP_RD: begin
            if (stat.scan_end) begin
               cmd.exp_done = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = S_EXP_CHK;
            end
         end
         S_EXP_CHK: begin
            cmd.exp_eval = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = S_EXP_RD;
         end
         S_MEAS_RD: begin
            if (stat.scan_end) begin
               state_in = S_MEAS_DEC;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = S_MEAS_CMP;
            end
         end
         S_MEAS_CMP: begin
            cmd.meas_cmp = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = S_MEAS_RD;
         end
         S_MEAS_DEC: begin
            cmd.meas_dec = 1'b1;
            state_in     = S_BLEND;
         end
         S_BLEND: begin
            cmd.blend = 1'b1;
            state_in  = S_MEAS_WR;
         end
         S_MEAS_WR: begin
            if (!stat.rsp_busy) begin
               cmd.meas_write = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_REP_RD: begin
            if (stat.scan_end || stat.rep_limit) begin
               state_in = S_EMIT;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = S_REP_CHK;
            end
         end
         S_REP_CHK: begin
            if (!stat.rep_hit) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_REP_RD;
            end else if (!stat.rsp_busy) begin
               cmd.rep_eval = 1'b1;
               cmd.idx_inc  = 1'b1;
               state_in     = S_REP_RD;
            end
         end
         S_EMIT: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               if (!stat.reported) cmd.rep_empty = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

// ----- hw/rtl/ntt_datapath.sv -----
// Datapath of the nearest track table: slot memory, distance compare, blend,
// output register. Depends on ntt_pkg and ntt_ram.
`timescale 1ns / 1ps

module ntt_datapath #(
   parameter int MaxTracks = ntt_pkg::MaxTracksDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ntt_pkg::req_word_type              req_word,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [ntt_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [31:0]                        csr_data,
   input  ntt_pkg::cmd_type                   cmd,
   output ntt_pkg::stat_type                  stat,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output ntt_pkg::rsp_word_type              rsp_word
);
   import ntt_pkg::*;

   localparam int AW = (MaxTracks > 1) ? $clog2(MaxTracks) : 1;
   localparam int CW = $clog2(MaxTracks + 1);
   localparam int TW = $bits(track_type);

   // Configuration registers.
   logic [30:0] match_ff, jump_ff;
   logic [16:0] weight_ff;
   logic [31:0] ttl_ff;
   logic [7:0]  min_hits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff    <= 31'd49152;
         jump_ff     <= 31'd39322;
         weight_ff   <= 17'd5243;
         ttl_ff      <= 32'd2000;
         min_hits_ff <= 8'd2;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MATCH_DISTANCE: match_ff    <= csr_data[30:0];
            CSR_JUMP_LIMIT:     jump_ff     <= csr_data[30:0];
            CSR_BLEND_WEIGHT:   weight_ff   <= csr_data[16:0];
            CSR_TIME_TO_LIVE:   ttl_ff      <= csr_data;
            CSR_MIN_HITS:       min_hits_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Control state.
   logic [CW-1:0] live_ff, idx_ff, keep_ff;
   logic [15:0]   next_id_ff;
   logic [31:0]   frame_ff;
   logic [4:0]    nrep_ff;
   req_word_type  req_ff;

   // Slot memory.
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   track_type     wr_data, rd_data;
   logic [TW-1:0] rd_raw;

   ntt_ram #(.Width(TW), .Depth(MaxTracks)) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_raw)
   );
   assign rd_data = track_type'(rd_raw);

   // Distance of the current slot to the measurement.
   logic signed [32:0] dx, dy;
   logic [32:0]        ax, ay;
   logic [65:0]        dsum;
   logic [63:0]        slot_dist;
   assign dx   = 33'(req_ff.meas_x) - 33'(rd_data.x);
   assign dy   = 33'(req_ff.meas_y) - 33'(rd_data.y);
   assign ax   = dx[32] ? 33'(-dx) : 33'(dx);
   assign ay   = dy[32] ? 33'(-dy) : 33'(dy);
   assign dsum = 66'(ax * ax) + 66'(ay * ay);
   assign slot_dist = (dsum[65:64] != 2'b00) ? '1 : dsum[63:0];

   logic          found_ff;
   logic [63:0]   best_d_ff;
   logic [AW-1:0] best_ff;
   track_type     best_rec_ff;

   // Decision registers.
   logic          upd_ff, rej_ff, full_ff;
   logic [61:0]   match_sq_ff, jump_sq_ff;
   logic signed [31:0] nx_ff, ny_ff;

   // Blend: ((65536-w)*old + w*meas + 32768) >> 16 with floor.
   logic [16:0] w_sat;
   assign w_sat = (weight_ff > 17'd65536) ? 17'd65536 : weight_ff;
   function automatic logic signed [31:0] blend_f(
      input logic signed [31:0] old_v, input logic signed [31:0] meas_v,
      input logic [16:0] w);
      logic signed [51:0] s;
      s = 52'(signed'({1'b0, 17'd65536 - w}) * old_v) +
          52'(signed'({1'b0, w}) * meas_v) + 52'sd32768;
      return s[47:16];
   endfunction

   // Report word for a held track.
   function automatic rsp_word_type track_word(input track_type t, input logic last);
      rsp_word_type r;
      r              = '0;
      r.kind         = KIND_TRACK;
      r.status       = ST_UPDATED;
      r.track_number = t.ident;
      r.pos_x        = t.x;
      r.pos_y        = t.y;
      r.hit_count    = t.hits;
      r.last_result  = last;
      return r;
   endfunction

   logic [31:0] idle;
   assign idle = frame_ff - rd_data.seen;

   rsp_word_type pend_ff, pend_in;
   logic         rsp_valid_ff, rsp_valid_in;
   track_type    hold_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = keep_ff[AW-1:0];
      wr_data = rd_data;
      if (cmd.exp_eval && idle <= ttl_ff) begin
         wr_en = 1'b1;
      end
      if (cmd.meas_write && !rej_ff) begin
         if (upd_ff) begin
            wr_en        = 1'b1;
            wr_addr      = best_ff;
            wr_data      = best_rec_ff;
            wr_data.x    = nx_ff;
            wr_data.y    = ny_ff;
            wr_data.seen = frame_ff;
            wr_data.hits = (best_rec_ff.hits == 8'hFF) ? 8'hFF : best_rec_ff.hits + 8'd1;
         end else if (!full_ff) begin
            wr_en         = 1'b1;
            wr_addr       = live_ff[AW-1:0];
            wr_data.x     = req_ff.meas_x;
            wr_data.y     = req_ff.meas_y;
            wr_data.seen  = frame_ff;
            wr_data.hits  = 8'd1;
            wr_data.ident = next_id_ff;
         end
      end
   end

   // Output register. A report track is held one step, so that only the final one
   // is sent with the last flag.
   always_comb begin
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.meas_write) begin
         rsp_valid_in        = 1'b1;
         pend_in             = '0;
         pend_in.kind        = KIND_STATUS;
         pend_in.last_result = 1'b1;
         if (rej_ff) begin
            pend_in.status       = ST_REJECTED;
            pend_in.track_number = best_rec_ff.ident;
            pend_in.pos_x        = best_rec_ff.x;
            pend_in.pos_y        = best_rec_ff.y;
            pend_in.hit_count    = best_rec_ff.hits;
         end else if (upd_ff) begin
            pend_in.status       = ST_UPDATED;
            pend_in.track_number = best_rec_ff.ident;
            pend_in.pos_x        = nx_ff;
            pend_in.pos_y        = ny_ff;
            pend_in.hit_count    = wr_data.hits;
         end else if (full_ff) begin
            pend_in.status = ST_FULL;
            pend_in.pos_x  = req_ff.meas_x;
            pend_in.pos_y  = req_ff.meas_y;
         end else begin
            pend_in.status       = ST_CREATED;
            pend_in.track_number = next_id_ff;
            pend_in.pos_x        = req_ff.meas_x;
            pend_in.pos_y        = req_ff.meas_y;
            pend_in.hit_count    = 8'd1;
         end
      end
      if (cmd.rep_eval && nrep_ff != 5'd0) begin
         rsp_valid_in = 1'b1;
         pend_in      = track_word(hold_ff, 1'b0);
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         if (cmd.rep_empty) begin
            pend_in             = '0;
            pend_in.kind        = KIND_EMPTY;
            pend_in.last_result = 1'b1;
         end else begin
            pend_in = track_word(hold_ff, 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff      <= '0;
         next_id_ff   <= '0;
         frame_ff     <= '0;
         idx_ff       <= '0;
         keep_ff      <= '0;
         nrep_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= '0;
         req_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         if (cmd.load_req) begin
            req_ff <= req_word;
            if (op_type'(req_word.operation) == OP_FRAME_START) begin
               frame_ff <= req_word.time_ms;
            end
         end
         if (cmd.clr_scan) begin
            idx_ff   <= '0;
            keep_ff  <= '0;
            nrep_ff  <= '0;
            found_ff <= 1'b0;
         end
         if (cmd.idx_inc) idx_ff <= idx_ff + CW'(1);
         if (cmd.exp_eval && idle <= ttl_ff) keep_ff <= keep_ff + CW'(1);
         if (cmd.exp_done) live_ff <= keep_ff;
         if (cmd.meas_cmp && (!found_ff || slot_dist < best_d_ff)) begin
            found_ff    <= 1'b1;
            best_d_ff   <= slot_dist;
            best_ff     <= idx_ff[AW-1:0];
            best_rec_ff <= rd_data;
         end
         if (cmd.clr_scan) begin
            match_sq_ff <= 62'(match_ff * match_ff);
            jump_sq_ff  <= 62'(jump_ff * jump_ff);
         end
         if (cmd.meas_dec) begin
            upd_ff  <= found_ff && best_d_ff < 64'(match_sq_ff) &&
                       !(best_d_ff > 64'(jump_sq_ff));
            rej_ff  <= found_ff && best_d_ff < 64'(match_sq_ff) &&
                       best_d_ff > 64'(jump_sq_ff);
            full_ff <= live_ff >= CW'(MaxTracks);
         end
         if (cmd.blend) begin
            nx_ff <= blend_f(best_rec_ff.x, req_ff.meas_x, w_sat);
            ny_ff <= blend_f(best_rec_ff.y, req_ff.meas_y, w_sat);
         end
         if (cmd.meas_write && !rej_ff && !upd_ff && !full_ff) begin
            live_ff    <= live_ff + CW'(1);
            next_id_ff <= next_id_ff + 16'd1;
         end
         if (cmd.rep_eval) begin
            nrep_ff <= nrep_ff + 5'd1;
            hold_ff <= rd_data;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = pend_ff;

   assign stat.op        = op_type'(cmd.load_req ? req_word.operation : req_ff.operation);
   assign stat.scan_end  = (idx_ff >= live_ff);
   assign stat.rep_hit   = (rd_data.hits >= min_hits_ff);
   assign stat.reported  = (nrep_ff != 5'd0);
   assign stat.rep_limit = (nrep_ff >= 5'(ResultLimit));
   assign stat.rsp_busy  = rsp_valid_ff && rsp_stall;
endmodule

// ----- hw/rtl/ntt_checker.sv -----
// Port-level checker of the nearest track table, bound to the top level.
// Depends on ntt_pkg for the word types and codes.
`timescale 1ns / 1ps

module ntt_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input ntt_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input ntt_pkg::rsp_word_type rsp_word
);
   import ntt_pkg::*;

   // A stalled result word holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed under stall");

   // A status or empty word always ends its request.
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.kind == KIND_STATUS || rsp_word.kind == KIND_EMPTY)
      |-> rsp_word.last_result)
      else $error("single result word without last flag");

   // The empty word carries a zero track number and hit count.
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.kind == KIND_EMPTY |->
      rsp_word.track_number == 16'd0 && rsp_word.hit_count == 8'd0)
      else $error("empty report word has data");

   // A request with work to do is not followed by another in the next cycle.
   a_seq: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_word.operation != OP_UNUSED |=> req_stall)
      else $error("request taken back to back");
endmodule

bind nearest_track_table ntt_checker u_ntt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
